[rtl/tli_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tli_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = 6;
    localparam int LEN_W       = 7;

    // Datapath widths.
    localparam int DATA_W    = 32;
    localparam int DIV_STEPS = DATA_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Command codes carried on the input channel.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

[rtl/table_linear_interpolator.sv]
// A query with n active entries scans them one entry per cycle through the single read port;
// when it interpolates it then runs the 32-step serial divider, and when it clamps or matches
// it skips the divider. The block takes no new beat, write or query, until the query's
// result has entered the output slot, which can stall on i_out_ready.
// Reset: i_rst_n is synchronous, active low; it clears the sequencer, the output slot and
// sets table_length to 1. Table contents are not cleared and are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module table_linear_interpolator (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration register: table_length.
    input  wire logic                         i_cfg_we,
    input  wire logic [tli_pkg::LEN_W-1:0]    i_cfg_wdata,
    // Input channel.
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_command,
    input  wire logic [tli_pkg::IDX_W-1:0]    i_entry_index,
    input  wire logic [tli_pkg::DATA_W-1:0]   i_entry_energy,
    input  wire logic [tli_pkg::DATA_W-1:0]   i_entry_value,
    input  wire logic [tli_pkg::DATA_W-1:0]   i_query_energy,
    // Output channel.
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [tli_pkg::DATA_W-1:0]        o_interpolated_value,
    output logic                              o_below_table,
    output logic                              o_above_table
);

    localparam int DW = tli_pkg::DATA_W;
    localparam int AW = tli_pkg::ADDR_W;

    // ------------------------------------------------------------------
    // Breakpoint memory. Each row holds {energy, value}. One write port
    // driven by write beats, one registered read port driven by the scan
    // address. The read runs every cycle; r_rd_vld marks when the data
    // belongs to the scan.
    // ------------------------------------------------------------------
    logic [2*DW-1:0] mem [tli_pkg::TABLE_DEPTH];
    logic [2*DW-1:0] r_rd;

    logic w_in_fire;
    logic w_wr_fire;

    assign w_in_fire = i_in_valid && o_in_ready;
    assign w_wr_fire = w_in_fire && (i_command == tli_pkg::CMD_WRITE);

    logic [DW-1:0] w_rd_e;
    logic [DW-1:0] w_rd_v;
    assign w_rd_e = r_rd[2*DW-1:DW];
    assign w_rd_v = r_rd[DW-1:0];

    // ------------------------------------------------------------------
    // Sequencer and datapath registers.
    // ------------------------------------------------------------------
    tli_pkg::t_state r_state, n_state;

    logic [tli_pkg::LEN_W-1:0] r_table_len;

    logic [AW-1:0]  r_addr,       n_addr;
    logic [AW-1:0]  r_last,       n_last;
    logic           r_issue_done, n_issue_done;
    logic           r_rd_vld,     n_rd_vld;
    logic [DW-1:0]  r_q,          n_q;

    // Best lower and upper neighbours found so far.
    logic           r_have_lo, n_have_lo;
    logic           r_have_hi, n_have_hi;
    logic [DW-1:0]  r_lo_e,    n_lo_e;
    logic [DW-1:0]  r_lo_v,    n_lo_v;
    logic [DW-1:0]  r_hi_e,    n_hi_e;
    logic [DW-1:0]  r_hi_v,    n_hi_v;

    // Interpolation operands and the serial divider.
    logic [DW-1:0]    r_dx,   n_dx;
    logic [DW-1:0]    r_off,  n_off;
    logic [DW-1:0]    r_dv,   n_dv;
    logic             r_desc, n_desc;
    logic [DW-1:0]    r_rem,  n_rem;
    logic [DW-1:0]    r_quo,  n_quo;
    logic [tli_pkg::CNT_W-1:0] r_cnt, n_cnt;

    // Output slot.
    logic           r_out_vld, n_out_vld;
    logic [DW-1:0]  r_out_val, n_out_val;
    logic           r_out_blw, n_out_blw;
    logic           r_out_abv, n_out_abv;

    always_ff @(posedge i_clk) begin
        if (w_wr_fire && (32'(i_entry_index) < tli_pkg::TABLE_DEPTH)) begin
            mem[i_entry_index[AW-1:0]] <= {i_entry_energy, i_entry_value};
        end
        r_rd <= mem[r_addr];
    end

    // The active entry count is table_length clamped into 1..TABLE_DEPTH;
    // the scan runs from entry 0 to r_last inclusive.
    logic [AW-1:0] w_last;
    always_comb begin
        if (r_table_len == '0) begin
            w_last = '0;
        end else if (r_table_len > tli_pkg::LEN_W'(tli_pkg::TABLE_DEPTH)) begin
            w_last = AW'(tli_pkg::TABLE_DEPTH - 1);
        end else begin
            w_last = AW'(r_table_len - tli_pkg::LEN_W'(1));
        end
    end

    // Neighbour update for the entry that the memory currently returns.
    // Strict compares keep the first entry among equal energies.
    logic w_lo_take;
    logic w_hi_take;
    assign w_lo_take = r_rd_vld && (w_rd_e <= r_q) && (!r_have_lo || (w_rd_e > r_lo_e));
    assign w_hi_take = r_rd_vld && (w_rd_e >= r_q) && (!r_have_hi || (w_rd_e < r_hi_e));

    // Product of offset and value span. The quotient of product / dx is
    // below 2^32 because the offset is at most dx, so the high half of the
    // product seeds the remainder and the low half is shifted in one bit
    // per divider step.
    logic [2*DW-1:0] w_prod;
    assign w_prod = r_off * r_dv;

    logic [DW:0] w_trial;
    logic [DW:0] w_diff;
    logic        w_ge;
    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_dx};
    assign w_ge    = (w_trial >= {1'b0, r_dx});

    // Falling segments round the drop up so the result still floors.
    logic [DW-1:0] w_up;
    assign w_up = r_quo + DW'(r_rem != '0);

    logic w_out_free;
    assign w_out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_last       = r_last;
        n_issue_done = r_issue_done;
        n_rd_vld     = 1'b0;
        n_q          = r_q;
        n_have_lo    = r_have_lo;
        n_have_hi    = r_have_hi;
        n_lo_e       = r_lo_e;
        n_lo_v       = r_lo_v;
        n_hi_e       = r_hi_e;
        n_hi_v       = r_hi_v;
        n_dx         = r_dx;
        n_off        = r_off;
        n_dv         = r_dv;
        n_desc       = r_desc;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_cnt        = r_cnt;
        n_out_vld    = r_out_vld && !i_out_ready;
        n_out_val    = r_out_val;
        n_out_blw    = r_out_blw;
        n_out_abv    = r_out_abv;
        o_in_ready   = 1'b0;

        unique case (r_state)
            tli_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && (i_command == tli_pkg::CMD_QUERY)) begin
                    n_state      = tli_pkg::ST_SCAN;
                    n_addr       = '0;
                    n_last       = w_last;
                    n_issue_done = 1'b0;
                    n_q          = i_query_energy;
                    n_have_lo    = 1'b0;
                    n_have_hi    = 1'b0;
                end
            end

            tli_pkg::ST_SCAN: begin
                // Issue one read a cycle and fold in the entry read last cycle.
                if (!r_issue_done) begin
                    n_rd_vld = 1'b1;
                    if (r_addr == r_last) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
                if (w_lo_take) begin
                    n_have_lo = 1'b1;
                    n_lo_e    = w_rd_e;
                    n_lo_v    = w_rd_v;
                end
                if (w_hi_take) begin
                    n_have_hi = 1'b1;
                    n_hi_e    = w_rd_e;
                    n_hi_v    = w_rd_v;
                end
                if (r_issue_done) begin
                    n_state = tli_pkg::ST_PREP;
                end
            end

            tli_pkg::ST_PREP: begin
                // A bracket whose lower neighbour lies strictly below the query needs
                // interpolation; everything else is settled in the final state from the neighbours alone.
                if (r_have_lo && r_have_hi && (r_lo_e != r_q)) begin
                    n_dx    = r_hi_e - r_lo_e;
                    n_off   = r_q - r_lo_e;
                    n_desc  = (r_hi_v < r_lo_v);
                    n_dv    = (r_hi_v < r_lo_v) ? (r_lo_v - r_hi_v) : (r_hi_v - r_lo_v);
                    n_state = tli_pkg::ST_MUL;
                end else begin
                    n_state = tli_pkg::ST_FIN;
                end
            end

            tli_pkg::ST_MUL: begin
                n_rem   = w_prod[2*DW-1:DW];
                n_quo   = w_prod[DW-1:0];
                n_cnt   = '0;
                n_state = tli_pkg::ST_DIV;
            end

            tli_pkg::ST_DIV: begin
                n_rem = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                n_quo = {r_quo[DW-2:0], w_ge};
                n_cnt = r_cnt + tli_pkg::CNT_W'(1);
                if (r_cnt == tli_pkg::CNT_W'(tli_pkg::DIV_STEPS - 1)) begin
                    n_state = tli_pkg::ST_FIN;
                end
            end

            tli_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_out_vld = 1'b1;
                    n_out_blw = 1'b0;
                    n_out_abv = 1'b0;
                    if (!r_have_lo) begin
                        n_out_val = r_hi_v;
                        n_out_blw = 1'b1;
                    end else if (!r_have_hi) begin
                        n_out_val = r_lo_v;
                        n_out_abv = 1'b1;
                    end else if (r_lo_e == r_q) begin
                        n_out_val = r_lo_v;
                    end else if (r_desc) begin
                        n_out_val = r_lo_v - w_up;
                    end else begin
                        n_out_val = r_lo_v + r_quo;
                    end
                    n_state = tli_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = tli_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tli_pkg::ST_IDLE;
            r_table_len  <= tli_pkg::LEN_RESET;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_issue_done <= n_issue_done;
            r_rd_vld     <= n_rd_vld;
            r_out_vld    <= n_out_vld;
            if (i_cfg_we) begin
                r_table_len <= i_cfg_wdata;
            end
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_last    <= n_last;
        r_q       <= n_q;
        r_have_lo <= n_have_lo;
        r_have_hi <= n_have_hi;
        r_lo_e    <= n_lo_e;
        r_lo_v    <= n_lo_v;
        r_hi_e    <= n_hi_e;
        r_hi_v    <= n_hi_v;
        r_dx      <= n_dx;
        r_off     <= n_off;
        r_dv      <= n_dv;
        r_desc    <= n_desc;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_cnt     <= n_cnt;
        r_out_val <= n_out_val;
        r_out_blw <= n_out_blw;
        r_out_abv <= n_out_abv;
    end

    assign o_out_valid          = r_out_vld;
    assign o_interpolated_value = r_out_val;
    assign o_below_table        = r_out_blw;
    assign o_above_table        = r_out_abv;

endmodule

`default_nettype wire

[rtl/tli_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tli_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_ready,
    input wire logic                       i_command,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [tli_pkg::DATA_W-1:0] o_interpolated_value,
    input wire logic                       o_below_table,
    input wire logic                       o_above_table
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_interpolated_value)
            && $stable(o_below_table) && $stable(o_above_table))
        else $error("result beat changed while stalled");

    // A query cannot be both below and above the table.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_below_table && o_above_table))
        else $error("both range flags set");

    // The block is ready again in the cycle after a write beat.
    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command == tli_pkg::CMD_WRITE) |=> o_in_ready)
        else $error("not ready after a write beat");

    // A query beat holds off input while it scans.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command == tli_pkg::CMD_QUERY) |=> !o_in_ready)
        else $error("ready right after a query beat");

endmodule

bind table_linear_interpolator tli_checker u_tli_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in_valid),
    .o_in_ready           (o_in_ready),
    .i_command            (i_command),
    .o_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .o_interpolated_value (o_interpolated_value),
    .o_below_table        (o_below_table),
    .o_above_table        (o_above_table)
);

`default_nettype wire
